>>> hw/rtl/pmds_pkg.sv
// ----------------------------------------------------------------------------
// pmds_pkg: shared types and constants for the phase MASH modulator
// Accumulator width, carry vector and level types, output offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pmds_pkg;

  localparam int unsigned AccWidth = 32;
  localparam int unsigned NumInt   = 4;
  localparam int unsigned NumCells = NumInt + 1;
  localparam int unsigned LevelW   = 4;
  localparam int unsigned SumW     = 5;

  typedef logic [AccWidth-1:0]     acc_t;
  typedef logic [NumInt-1:0]       carry_t;
  typedef logic [LevelW-1:0]       level_t;
  typedef logic signed [SumW-1:0]  sum_t;

  localparam sum_t LevelOffset = sum_t'(7);

endpackage

`default_nettype wire

>>> hw/rtl/pmds_cell.sv
// ----------------------------------------------------------------------------
// pmds_cell: one wrapping accumulator cell of the chain
// Adds the incoming value to its own state, keeps the sum as both state and
// handoff data, and shifts its carry into the carry vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmds_cell (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    valid_i,
  output logic                   stall_o,
  input  pmds_pkg::acc_t         data_i,
  input  pmds_pkg::carry_t       carry_i,
  output logic                   valid_o,
  input  wire                    stall_i,
  output pmds_pkg::acc_t         data_o,
  output pmds_pkg::carry_t       carry_o
);

  logic                        valid_q, valid_d;
  pmds_pkg::acc_t              acc_q;
  pmds_pkg::carry_t            carry_q;
  logic [pmds_pkg::AccWidth:0] sum_w;
  logic                        take_w;

  assign stall_o = valid_q && stall_i;
  assign take_w  = valid_i && !stall_o;
  assign sum_w   = {1'b0, acc_q} + {1'b0, data_i};

  always_comb begin
    valid_d = valid_q;
    if (take_w) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      acc_q   <= '0;
      carry_q <= '0;
    end else begin
      valid_q <= valid_d;
      if (take_w) begin
        acc_q   <= sum_w[pmds_pkg::AccWidth-1:0];
        carry_q <= {carry_i[pmds_pkg::NumInt-2:0], sum_w[pmds_pkg::AccWidth]};
      end
    end
  end

  assign valid_o = valid_q;
  assign data_o  = acc_q;
  assign carry_o = carry_q;

  // held request keeps its data
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && stall_i |=> valid_q && $stable(acc_q) && $stable(carry_q))
    else $error("cell lost a held request");

  // state only moves on an accepted request
  a_acc_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_w |=> $stable(acc_q))
    else $error("cell state changed without a request");

endmodule

`default_nettype wire

>>> hw/rtl/pmds_combine.sv
// ----------------------------------------------------------------------------
// pmds_combine: noise-shaping recombination and output register
// Folds the four carries through the difference stages and presents the
// offset level in a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmds_combine (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    valid_i,
  output logic                   stall_o,
  input  pmds_pkg::carry_t       carry_i,
  output logic                   valid_o,
  input  wire                    stall_i,
  output pmds_pkg::level_t       level_o
);

  logic                 valid_q, valid_d;
  pmds_pkg::level_t     level_q;
  logic                 c4_delay_q;
  logic signed [2:0]    s3_delay_q;
  logic signed [3:0]    s2_delay_q;
  pmds_pkg::sum_t       s3_w, s2_w, y_w, lvl_w;
  logic                 take_w;

  // carry_i: [3]=c1 [2]=c2 [1]=c3 [0]=c4
  assign s3_w  = pmds_pkg::sum_t'({1'b0, carry_i[1]}) + pmds_pkg::sum_t'({1'b0, carry_i[0]})
               - pmds_pkg::sum_t'({1'b0, c4_delay_q});
  assign s2_w  = pmds_pkg::sum_t'({1'b0, carry_i[2]}) + s3_w
               - pmds_pkg::sum_t'(s3_delay_q);
  assign y_w   = pmds_pkg::sum_t'({1'b0, carry_i[3]}) + s2_w
               - pmds_pkg::sum_t'(s2_delay_q);
  assign lvl_w = y_w + pmds_pkg::LevelOffset;

  assign stall_o = valid_q && stall_i;
  assign take_w  = valid_i && !stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take_w) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      c4_delay_q <= 1'b0;
      s3_delay_q <= '0;
      s2_delay_q <= '0;
    end else begin
      valid_q <= valid_d;
      if (take_w) begin
        c4_delay_q <= carry_i[0];
        s3_delay_q <= s3_w[2:0];
        s2_delay_q <= s2_w[3:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_w) begin
      level_q <= lvl_w[pmds_pkg::LevelW-1:0];
    end
  end

  assign valid_o = valid_q;
  assign level_o = level_q;

  a_s3_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_delay_q >= -3'sd1 && s3_delay_q <= 3'sd2)
    else $error("stage3 delay out of range");

  a_s2_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_delay_q >= -4'sd3 && s2_delay_q <= 4'sd4)
    else $error("stage2 delay out of range");

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_w |-> (y_w >= -5'sd7 && y_w <= 5'sd8))
    else $error("modulator sum out of range");

endmodule

`default_nettype wire

>>> hw/rtl/phase_mash_delta_sigma_top.sv
// ----------------------------------------------------------------------------
// phase_mash_delta_sigma_top: phase accumulator and MASH 1-1-1-1 modulator
// Flow: an accepted request passes five adder cells and the output stage
//   before level_o is valid, and waits in place while out_stall_i is held.
// Throughput: unstalled, one request and one 32-bit add per cell per cycle.
// Reset: rst_ni clears the phase, all integrators and the difference delays.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phase_mash_delta_sigma_top (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  pmds_pkg::acc_t     phase_step_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output pmds_pkg::level_t   level_o
);

  logic             valid_w [pmds_pkg::NumCells+1];
  logic             stall_w [pmds_pkg::NumCells+1];
  pmds_pkg::acc_t   data_w  [pmds_pkg::NumCells+1];
  pmds_pkg::carry_t carry_w [pmds_pkg::NumCells+1];

  assign valid_w[0] = in_valid_i;
  assign data_w[0]  = phase_step_i;
  assign carry_w[0] = '0;
  assign in_stall_o = stall_w[0];

  // cell 0 is the phase accumulator, cells 1..4 the integrators
  for (genvar k = 0; k < pmds_pkg::NumCells; k++) begin : g_cell
    pmds_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[k]),
      .stall_o (stall_w[k]),
      .data_i  (data_w[k]),
      .carry_i (carry_w[k]),
      .valid_o (valid_w[k+1]),
      .stall_i (stall_w[k+1]),
      .data_o  (data_w[k+1]),
      .carry_o (carry_w[k+1])
    );
  end

  pmds_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_w[pmds_pkg::NumCells]),
    .stall_o (stall_w[pmds_pkg::NumCells]),
    .carry_i (carry_w[pmds_pkg::NumCells]),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .level_o (level_o)
  );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: phase_mash_delta_sigma_top self-checking bench
// Feeds phase increments over the valid/stall request channel with random
// gaps and output stalls. A scoreboard models the phase accumulator and the
// MASH 1-1-1-1 cascade, queues expected levels and checks each one in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 12;
  localparam int MaxReport   = 10;

  class level_scoreboard;
    pmds_pkg::acc_t     phase;
    pmds_pkg::acc_t     integ[pmds_pkg::NumInt];
    int                 carry4_q;
    int                 stage3_q;
    int                 stage2_q;
    pmds_pkg::level_t   expected_levels[$];
    int                 mismatches;

    function new();
      phase      = '0;
      foreach (integ[i]) integ[i] = '0;
      carry4_q   = 0;
      stage3_q   = 0;
      stage2_q   = 0;
      mismatches = 0;
    endfunction

    function void note_step(pmds_pkg::acc_t step);
      logic [pmds_pkg::AccWidth:0] sum;
      pmds_pkg::acc_t              v;
      int                          c[pmds_pkg::NumInt];
      int                          s3, s2, y;
      phase = phase + step;
      v = phase;
      for (int i = 0; i < pmds_pkg::NumInt; i++) begin
        sum      = {1'b0, integ[i]} + {1'b0, v};
        c[i]     = int'(sum[pmds_pkg::AccWidth]);
        integ[i] = sum[pmds_pkg::AccWidth-1:0];
        v        = integ[i];
      end
      s3 = c[3] + c[2] - carry4_q;
      s2 = c[1] + s3 - stage3_q;
      y  = c[0] + s2 - stage2_q;
      carry4_q = c[3];
      stage3_q = s3;
      stage2_q = s2;
      expected_levels.push_back(pmds_pkg::level_t'(y + 7));
    endfunction

    function void check_level(pmds_pkg::level_t got);
      pmds_pkg::level_t want;
      if (expected_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReport)
          $display("%0t: unexpected level %0d, none pending", $time, got);
        return;
      end
      want = expected_levels.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxReport)
          $display("%0t: level mismatch, expected %0d, got %0d", $time, want, got);
      end
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  pmds_pkg::acc_t   phase_step_i = '0;
  logic             out_stall_i  = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  pmds_pkg::level_t level_o;

  level_scoreboard sb;
  bit tx_idle       = 1'b1;
  bit rx_idle       = 1'b1;
  int rx_hold_count = 0;
  int cycle_count   = 0;

  phase_mash_delta_sigma_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .phase_step_i (phase_step_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .level_o      (level_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial sb = new();

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_step(phase_step_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_level(level_o);
  end

  // receiver: random stall before each level while rx_idle is set, or one long hold on demand
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (rx_hold_count > 0) begin
        n = rx_hold_count;
        rx_hold_count = 0;
      end else begin
        n = rx_idle ? $urandom_range(0, 4) : 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_step(input pmds_pkg::acc_t step);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    phase_step_i <= step;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_levels();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic pmds_pkg::acc_t pick_step();
    pmds_pkg::acc_t v;
    case ($urandom_range(0, 5))
      0:       v = pmds_pkg::acc_t'($urandom_range(0, 255));
      1:       v = ~pmds_pkg::acc_t'($urandom_range(0, 255));
      2:       v = pmds_pkg::acc_t'(1) << $urandom_range(0, pmds_pkg::AccWidth - 1);
      3:       v = pmds_pkg::acc_t'($urandom) >> $urandom_range(0, pmds_pkg::AccWidth - 1);
      default: v = pmds_pkg::acc_t'($urandom);
    endcase
    return v;
  endfunction

  // mostly steady tones (a step held for a run), some noise in between
  task automatic run_random(input int count);
    pmds_pkg::acc_t step;
    int             len;
    while (count > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        step = pick_step();
        len  = $urandom_range(1, 24);
        for (int i = 0; i < len && count > 0; i++) begin
          send_step(step);
          count--;
        end
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len && count > 0; i++) begin
          send_step(pick_step());
          count--;
        end
      end
    end
  endtask

  initial begin
    pmds_pkg::acc_t directed[$] = '{
      32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
      32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000, 32'h0000_0000,
      32'hFFFF_FFFF, 32'h0000_0001, 32'hC000_0000, 32'hC000_0000,
      32'h4000_0001, 32'hFFFF_FFFE
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_step(directed[i]);
    drain_levels();

    run_random(500);

    // hold the output long enough that the pipeline backs up into the input
    tx_idle = 1'b0;
    rx_hold_count = 300;
    repeat (2) @(posedge clk_i);
    run_random(60);
    drain_levels();

    rx_idle = 1'b0;
    run_random(400);
    rx_idle = 1'b1;
    run_random(250);
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    run_random(240);
    rx_idle = 1'b1;

    drain_levels();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
